// ----- design/bitmap_extent_extractor_macros.svh -----
// Assertion macros for the bitmap extent extractor.
// Included by the files that assert; depends on nothing else.
`ifndef BITMAP_EXTENT_EXTRACTOR_MACROS_SVH
`define BITMAP_EXTENT_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BEE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bitmap extent extractor: check failed");

// Next-cycle implication, disabled while reset is asserted
`define BEE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bitmap extent extractor: check failed");

`endif

// ----- design/bee_pkg.sv -----
// Shared widths, codes and types for the bitmap extent extractor.
// No dependencies; used by the channel interfaces, the top level and the test.
package bee_pkg;

	localparam int BYTE_W  = 8;
	localparam int START_W = 48;
	localparam int LEN_W   = 49;
	localparam int MAX_EXT = 4;

	// request codes
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// result codes
	localparam logic KIND_EXTENT  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// one closed run of a byte: start offset in the byte, or carried from an
	// earlier byte, and the offset of the free bit that closed it
	typedef struct packed {
		logic       carried;
		logic [2:0] s_off;
		logic [3:0] e_off;
	} ext_ent_t;

endpackage

// ----- design/bee_if.sv -----
// Request and result channel interfaces of the bitmap extent extractor.
// Depends on bee_pkg for the payload widths.
interface bee_req_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [bee_pkg::BYTE_W-1:0] bitmap_byte;

	modport source (output valid, req_type, bitmap_byte, input ready);
	modport sink   (input valid, req_type, bitmap_byte, output ready);
endinterface

interface bee_res_if;
	logic                        valid;
	logic                        ready;
	logic                        result_kind;
	logic [bee_pkg::START_W-1:0] extent_start;
	logic [bee_pkg::LEN_W-1:0]   extent_length;
	logic [bee_pkg::LEN_W-1:0]   used_count;
	logic                        last_of_run;

	modport source (output valid, result_kind, extent_start, extent_length, used_count,
		last_of_run, input ready);
	modport sink   (input valid, result_kind, extent_start, extent_length, used_count,
		last_of_run, output ready);
endinterface

// ----- design/bitmap_extent_extractor.sv -----
// Bitmap extent extractor top level: allocation bitmap bytes in, extents and summary out.
// Depends on bee_pkg, bee_if.sv and bitmap_extent_extractor_macros.svh.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------------
//  req     | in  | valid/ready         | req_type, bitmap_byte
//  res     | out | valid/ready         | result_kind, extent_start, extent_length,
//          |     |                     | used_count, last_of_run
//  cfg     | in  | cfg_we (no ready)   | cfg_data -> limit_q
//
// A request is decoded in the cycle it is accepted; its results (0 to 4) sit in a batch
// register and drain through a single result register at one result per cycle while the
// result side is ready; the next request is taken as a batch's last result is loaded.
// Reset clears the limit and all stream state at once; no clearing pass is needed.
// A stalled result side holds the result register; requests stall while a batch drains.
`include "bitmap_extent_extractor_macros.svh"

module bitmap_extent_extractor #(
	parameter int CLUSTER_BITS = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bee_pkg::START_W-1:0] cfg_data,
	bee_req_if.sink                     req,
	bee_res_if.source                   res
);

	localparam int LW = (CLUSTER_BITS < bee_pkg::START_W) ? CLUSTER_BITS : bee_pkg::START_W;
	localparam int IW = LW + 1;

	// stream state
	logic [LW-1:0] limit_q;
	logic [IW-1:0] index_q;
	logic [LW-1:0] run_start_q;
	logic          in_run_q;
	logic [IW-1:0] alloc_q;

	// decode
	logic             in_range;
	logic [IW-1:0]    rem;
	logic [3:0]       nvalid;
	logic [7:0]       vmask;
	logic [7:0]       bits;
	logic             run;
	logic             cur_carried;
	logic [2:0]       cur_s;
	logic [2:0]       k;
	logic [3:0]       pop;
	bee_pkg::ext_ent_t ent_d [bee_pkg::MAX_EXT];
	logic [2:0]       ent_cnt_d;
	logic             sum_d;
	logic             has_res;
	logic [IW-1:0]    index_d;
	logic [IW-1:0]    alloc_d;
	logic [LW-1:0]    run_start_d;
	logic             in_run_d;
	logic [IW-1:0]    clen_d;
	logic             accept;

	// batch of results of one request
	logic             batch_valid_q;
	logic [2:0]       ptr_q;
	bee_pkg::ext_ent_t ent_s1 [bee_pkg::MAX_EXT];
	logic [2:0]       ent_cnt_s1;
	logic             sum_s1;
	logic [IW-1:0]    used_s1;
	logic [IW-1:0]    index_s1;
	logic [LW-1:0]    rstart_s1;
	logic [IW-1:0]    clen_s1;

	// emitter
	logic [2:0]        total;
	logic              is_ext;
	logic              last;
	logic              load;
	bee_pkg::ext_ent_t cur;
	logic [LW-1:0]     ext_start;
	logic [IW-1:0]     ext_len;

	// result register
	logic                        out_valid_q;
	logic                        res_kind_q;
	logic [bee_pkg::START_W-1:0] res_start_q;
	logic [bee_pkg::LEN_W-1:0]   res_len_q;
	logic [bee_pkg::LEN_W-1:0]   res_used_q;
	logic                        res_last_q;

	always_comb begin
		in_range = (index_q <= {1'b0, limit_q});
		rem      = {1'b0, limit_q} - index_q;
		if (!in_range) begin
			nvalid = 4'd0;
		end else if (rem >= IW'(7)) begin
			nvalid = 4'd8;
		end else begin
			nvalid = {1'b0, rem[2:0]} + 4'd1;
		end
		for (int b = 0; b < 8; b++) begin
			vmask[b] = (4'(b) < nvalid);
		end
		bits = req.bitmap_byte & vmask;

		// walk the valid bits, closing runs on a free bit
		run         = in_run_q;
		cur_carried = 1'b1;
		cur_s       = 3'd0;
		k           = 3'd0;
		pop         = 4'd0;
		for (int i = 0; i < bee_pkg::MAX_EXT; i++) begin
			ent_d[i] = '0;
		end
		for (int b = 0; b < 8; b++) begin
			if (vmask[b]) begin
				if (run && !bits[b]) begin
					if (k < 3'd4) begin
						ent_d[k[1:0]] = '{carried: cur_carried, s_off: cur_s, e_off: 4'(b)};
					end
					k   = k + 3'd1;
					run = 1'b0;
				end else if (!run && bits[b]) begin
					cur_s       = 3'(b);
					cur_carried = 1'b0;
					run         = 1'b1;
				end
			end
			pop = pop + 4'(bits[b]);
		end

		clen_d = index_q - {1'b0, run_start_q};

		if (req.req_type == bee_pkg::REQ_END) begin
			// flush an open run, then report and clear
			for (int i = 0; i < bee_pkg::MAX_EXT; i++) begin
				ent_d[i] = '0;
			end
			ent_d[0]    = '{carried: 1'b1, s_off: 3'd0, e_off: 4'd0};
			ent_cnt_d   = {2'b00, in_run_q};
			sum_d       = 1'b1;
			index_d     = '0;
			alloc_d     = '0;
			run_start_d = '0;
			in_run_d    = 1'b0;
		end else begin
			ent_cnt_d   = k;
			sum_d       = 1'b0;
			index_d     = index_q + IW'(nvalid);
			alloc_d     = alloc_q + IW'(pop);
			in_run_d    = run;
			run_start_d = (run && !cur_carried) ? LW'(index_q + IW'(cur_s)) : run_start_q;
		end
		has_res = (ent_cnt_d != 3'd0) || sum_d;
	end

	always_comb begin
		total     = ent_cnt_s1 + {2'b00, sum_s1};
		is_ext    = (ptr_q < ent_cnt_s1);
		last      = (ptr_q == (total - 3'd1));
		cur       = ent_s1[ptr_q[1:0]];
		ext_start = cur.carried ? rstart_s1 : LW'(index_s1 + IW'(cur.s_off));
		ext_len   = cur.carried ? (clen_s1 + IW'(cur.e_off))
			: IW'(cur.e_off - {1'b0, cur.s_off});
		load      = batch_valid_q && (!out_valid_q || res.ready);
	end

	assign req.ready = !batch_valid_q || (load && last);
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_data[LW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q     <= '0;
			alloc_q     <= '0;
			run_start_q <= '0;
			in_run_q    <= 1'b0;
		end else if (accept) begin
			index_q     <= index_d;
			alloc_q     <= alloc_d;
			run_start_q <= run_start_d;
			in_run_q    <= in_run_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_valid_q <= 1'b0;
			ptr_q         <= 3'd0;
		end else if (accept) begin
			batch_valid_q <= has_res;
			ptr_q         <= 3'd0;
		end else if (load) begin
			if (last) begin
				batch_valid_q <= 1'b0;
				ptr_q         <= 3'd0;
			end else begin
				ptr_q <= ptr_q + 3'd1;
			end
		end
	end

	// snapshot of the state the results are computed from
	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1     <= ent_d;
			ent_cnt_s1 <= ent_cnt_d;
			sum_s1     <= sum_d;
			used_s1    <= alloc_q;
			index_s1   <= index_q;
			rstart_s1  <= run_start_q;
			clen_s1    <= clen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_kind_q  <= is_ext ? bee_pkg::KIND_EXTENT : bee_pkg::KIND_SUMMARY;
			res_start_q <= is_ext ? bee_pkg::START_W'(ext_start) : '0;
			res_len_q   <= is_ext ? bee_pkg::LEN_W'(ext_len) : '0;
			res_used_q  <= is_ext ? '0 : bee_pkg::LEN_W'(used_s1);
			res_last_q  <= last;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.result_kind   = res_kind_q;
	assign res.extent_start  = res_start_q;
	assign res.extent_length = res_len_q;
	assign res.used_count    = res_used_q;
	assign res.last_of_run   = res_last_q;

	`BEE_ASSERT_IMP(a_ptr_in_batch, clk, arst_n, batch_valid_q, ptr_q < total)
	`BEE_ASSERT_IMP(a_summary_last, clk, arst_n,
		out_valid_q && (res_kind_q == bee_pkg::KIND_SUMMARY), res_last_q)
	`BEE_ASSERT_IMP(a_extent_nonzero, clk, arst_n,
		out_valid_q && (res_kind_q == bee_pkg::KIND_EXTENT), res_len_q != '0)
	`BEE_ASSERT_NXT(a_end_clears, clk, arst_n,
		accept && (req.req_type == bee_pkg::REQ_END),
		(index_q == '0) && (alloc_q == '0) && !in_run_q)

endmodule

// ----- dv/bitmap_extent_extractor_test.sv -----
// Self-checking test of bitmap_extent_extractor: allocation bytes and end requests in,
// extent and summary records out, each compared with an in-bench prediction.
// Depends on bee_pkg, bee_if.sv and the bitmap_extent_extractor top level.
module bitmap_extent_extractor_test;

	localparam int          SETTLE_CYCLES = 6;
	localparam int          CHOKE_CYCLES  = 80;
	localparam int          QUIET_LIMIT   = 3000;
	localparam logic [47:0] LIMIT_MAX     = 48'hFFFF_FFFF_FFFF;

	typedef struct {
		logic        kind;
		logic [47:0] start;
		logic [48:0] length;
		logic [48:0] used;
		logic        last;
	} extent_rec_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [47:0] cfg_data;

	bee_req_if req_if ();
	bee_res_if res_if ();

	bitmap_extent_extractor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_if),
		.res      (res_if)
	);

	// predicted block state
	logic [47:0] limit_reg;
	logic [48:0] scan_pos;
	logic [47:0] run_first;
	logic        run_open;
	logic [48:0] used_total;

	extent_rec_t owed_records[$];
	int          fail_count;
	bit          idle_on;
	bit          choke_results;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Work out the records one request gives and queue them.
	function automatic void walk_request(input logic kind, input logic [7:0] bits);
		extent_rec_t recs[$];
		extent_rec_t r;
		if (kind == bee_pkg::REQ_BYTE) begin
			for (int b = 0; b < 8; b++) begin
				if (scan_pos > {1'b0, limit_reg})
					break;
				if (run_open && !bits[b]) begin
					r = '{bee_pkg::KIND_EXTENT, run_first,
						scan_pos - {1'b0, run_first}, '0, 1'b0};
					recs.push_back(r);
					run_open = 1'b0;
				end else if (!run_open && bits[b]) begin
					run_first = scan_pos[47:0];
					run_open  = 1'b1;
				end
				if (bits[b])
					used_total++;
				scan_pos++;
			end
		end else begin
			if (run_open) begin
				r = '{bee_pkg::KIND_EXTENT, run_first,
					scan_pos - {1'b0, run_first}, '0, 1'b0};
				recs.push_back(r);
			end
			r = '{bee_pkg::KIND_SUMMARY, '0, '0, used_total, 1'b0};
			recs.push_back(r);
			scan_pos   = '0;
			run_first  = '0;
			run_open   = 1'b0;
			used_total = '0;
		end
		if (recs.size() > 0)
			recs[recs.size()-1].last = 1'b1;
		foreach (recs[i])
			owed_records.push_back(recs[i]);
	endfunction

	function automatic void check_field(input string name, input logic [48:0] want,
		input logic [48:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Send one request and predict its records once it is taken.
	task automatic push_request(input logic kind, input logic [7:0] bits);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.req_type    <= kind;
		req_if.bitmap_byte <= bits;
		do
			@(posedge clk);
		while (!req_if.ready);
		walk_request(kind, bits);
	endtask

	// Hold requests until every owed record is out and the block has gone quiet.
	task automatic drain;
		req_if.valid <= 1'b0;
		while (owed_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [47:0] value);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_reg  = value;
	endtask

	function automatic logic [7:0] pick_byte;
		case ($urandom_range(0, 5))
			0: pick_byte = 8'h00;
			1: pick_byte = 8'hFF;
			2: pick_byte = $urandom_range(0, 1) ? 8'h55 : 8'hAA;
			3: pick_byte = 8'h01 << $urandom_range(0, 7);
			4: pick_byte = ~(8'h01 << $urandom_range(0, 7));
			default: pick_byte = 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Limit is zero after reset: only cluster 0 counts. Also an empty bitmap.
	task automatic test_reset_limit;
		push_request(bee_pkg::REQ_END, 8'h00);
		push_request(bee_pkg::REQ_BYTE, 8'hFF);
		push_request(bee_pkg::REQ_BYTE, 8'hFE);
		push_request(bee_pkg::REQ_END, 8'h00);
	endtask

	task automatic test_byte_patterns;
		set_limit(LIMIT_MAX);
		push_request(bee_pkg::REQ_BYTE, 8'h00);
		push_request(bee_pkg::REQ_BYTE, 8'hFF);
		// four runs close in one byte
		push_request(bee_pkg::REQ_BYTE, 8'h55);
		push_request(bee_pkg::REQ_BYTE, 8'hAA);
		push_request(bee_pkg::REQ_BYTE, 8'h01);
		push_request(bee_pkg::REQ_BYTE, 8'h80);
		// open run flushed; byte field ignored
		push_request(bee_pkg::REQ_END, 8'hFF);
		push_request(bee_pkg::REQ_BYTE, 8'h0F);
		push_request(bee_pkg::REQ_BYTE, 8'hF0);
		push_request(bee_pkg::REQ_END, 8'h5A);
	endtask

	task automatic test_limit_edges;
		set_limit(48'd20);
		repeat (4) push_request(bee_pkg::REQ_BYTE, 8'hFF);
		push_request(bee_pkg::REQ_END, 8'h00);
		// leave a run open at the limit, then raise the limit mid-stream
		set_limit(48'd5);
		push_request(bee_pkg::REQ_BYTE, 8'hE0);
		set_limit(48'd100);
		push_request(bee_pkg::REQ_BYTE, 8'h02);
		push_request(bee_pkg::REQ_END, 8'h00);
	endtask

	// Starve the result side while requests keep coming, so the block stalls its input.
	task automatic test_backpressure;
		set_limit(LIMIT_MAX);
		choke_results = 1'b1;
		for (int i = 0; i < 16; i++)
			push_request(bee_pkg::REQ_BYTE, i[0] ? 8'hAA : 8'h55);
		push_request(bee_pkg::REQ_END, 8'h00);
		drain();
	endtask

	task automatic test_random_streams;
		int          sent;
		int          len;
		logic [47:0] value;
		sent = 0;
		while (sent < 100) begin
			case ($urandom_range(0, 4))
				0: set_limit(48'($urandom_range(0, 40)));
				1: set_limit(48'($urandom_range(41, 400)));
				2: set_limit(LIMIT_MAX);
				3: begin
					value = {16'($urandom), 32'($urandom)};
					set_limit(value);
				end
				default: ;
			endcase
			len = $urandom_range(0, 10);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0)
					set_limit(48'($urandom_range(0, 120)));
				push_request(bee_pkg::REQ_BYTE, pick_byte());
				sent++;
			end
			push_request(bee_pkg::REQ_END, 8'($urandom_range(0, 255)));
			sent++;
		end
	endtask

	task automatic test_steady_flow;
		idle_on = 1'b0;
		set_limit(LIMIT_MAX);
		for (int i = 0; i < 30; i++)
			push_request(($urandom_range(0, 6) == 0) ? bee_pkg::REQ_END : bee_pkg::REQ_BYTE,
				pick_byte());
		push_request(bee_pkg::REQ_END, 8'h00);
	endtask

	// result sink: random holds, one long choke on request
	initial begin
		res_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (choke_results) begin
				res_if.ready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
				choke_results = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				res_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		extent_rec_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (owed_records.size() == 0) begin
				$error("unexpected record: kind %0h start %0h length %0h used %0h",
					res_if.result_kind, res_if.extent_start, res_if.extent_length,
					res_if.used_count);
				fail_count++;
			end else begin
				want = owed_records.pop_front();
				check_field("result_kind", want.kind, res_if.result_kind);
				check_field("extent_start", want.start, res_if.extent_start);
				check_field("extent_length", want.length, res_if.extent_length);
				check_field("used_count", want.used, res_if.used_count);
				check_field("last_of_run", want.last, res_if.last_of_run);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("bitmap_extent_extractor verification failed");
		$finish;
	end

	initial begin
		fail_count    = 0;
		idle_on       = 1'b1;
		choke_results = 1'b0;
		limit_reg     = '0;
		scan_pos      = '0;
		run_first     = '0;
		run_open      = 1'b0;
		used_total    = '0;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_data           <= '0;
		req_if.valid       <= 1'b0;
		req_if.req_type    <= bee_pkg::REQ_BYTE;
		req_if.bitmap_byte <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_limit();
		test_byte_patterns();
		test_limit_edges();
		test_backpressure();
		test_random_streams();
		test_steady_flow();

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("bitmap_extent_extractor verification clean");
		else
			$display("bitmap_extent_extractor verification failed");
		$finish;
	end

endmodule
